/* rtl/bmir_pkg.sv */
package bmir_pkg;

  // Widest block index for the largest frame store the design supports
  localparam int unsigned IDX_MAX_W   = 16;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned CFG_DATA_W  = 13;
  localparam int unsigned CFG_IDX_W   = 2;

  localparam logic [7:0] LITERAL_CODE = 8'hFF;
  localparam logic [7:0] INTER_FLAG   = 8'h80;
  localparam logic [7:0] OFFSET_MASK  = 8'h7F;

  localparam logic [12:0] RST_BLOCKS_PER_ROW = 13'd64;
  localparam logic [12:0] RST_BLOCK_COUNT    = 13'd4096;
  localparam logic [6:0]  RST_OFFSET_BIAS    = 7'd16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLOCKS_PER_ROW = 2'd0,
    CFG_BLOCK_COUNT    = 2'd1,
    CFG_OFFSET_BIAS    = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SRC_LITERAL = 2'd0,
    SRC_INTER   = 2'd1,
    SRC_INTRA   = 2'd2
  } src_kind_e;

  typedef enum logic [1:0] {
    FLT_NONE        = 2'd0,
    FLT_RANGE       = 2'd1,
    FLT_NO_PREV     = 2'd2,
    FLT_NOT_DECODED = 2'd3
  } fault_e;

  typedef struct packed {
    logic [7:0]  motion_x_code;
    logic [7:0]  motion_y_code;
    logic [31:0] literal_word;
  } in_t;

  typedef struct packed {
    logic [11:0] block_index;
    logic [31:0] interp_word;
    src_kind_e   source_kind;
    fault_e      fault;
    logic        frame_done;
  } out_t;

  typedef struct packed {
    logic [12:0] blocks_per_row;
    logic [12:0] block_count;
    logic [6:0]  offset_bias;
  } cfg_t;

  // Classified block handed from the front to the back
  typedef struct packed {
    logic [IDX_MAX_W-1:0] index;
    logic                 cur_bank;
    logic                 rd_en;
    logic                 rd_bank;
    logic [IDX_MAX_W-1:0] rd_index;
    src_kind_e            kind;
    fault_e               fault;
    logic                 frame_done;
    logic [31:0]          literal_word;
  } job_t;

endpackage

/* rtl/block_motion_index_reconstruct_unit.sv */
// Throughput: one block per cycle when the output does not stall; front (reference multiply,
// checks) and back (store read, write and bypass) each run a two-register pipeline, joined
// by a four-entry queue.
// Intra references to the block just written are served by the bypass, not the store.
// Reset: asynchronous, active low; clears counters, bank, previous-frame flag and the
// pipeline; registers return to their reset values, frame stores hold unknown data.
module block_motion_index_reconstruct_unit import bmir_pkg::*; #(
  parameter int unsigned MAX_BLOCKS = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_t                   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_t                  out_data_o
);

  cfg_t cfg_q;
  logic job_push, job_full, job_valid, job_pop;
  job_t job_in, job_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.blocks_per_row <= RST_BLOCKS_PER_ROW;
      cfg_q.block_count    <= RST_BLOCK_COUNT;
      cfg_q.offset_bias    <= RST_OFFSET_BIAS;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_BLOCKS_PER_ROW: cfg_q.blocks_per_row <= cfg_wdata_i;
        CFG_BLOCK_COUNT:    cfg_q.block_count    <= cfg_wdata_i;
        CFG_OFFSET_BIAS:    cfg_q.offset_bias    <= cfg_wdata_i[6:0];
        default: begin
        end
      endcase
    end
  end

  bmir_front #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .job_valid_o(job_push),
    .job_full_i (job_full),
    .job_o      (job_in)
  );

  bmir_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .data_i (job_in),
    .full_o (job_full),
    .valid_o(job_valid),
    .pop_i  (job_pop),
    .data_o (job_out)
  );

  bmir_back #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(job_valid),
    .job_i      (job_out),
    .job_pop_o  (job_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

/* rtl/bmir_front.sv */
module bmir_front import bmir_pkg::*; #(
  parameter int unsigned MAX_BLOCKS = 4096
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic job_valid_o,
  input  logic job_full_i,
  output job_t job_o
);

  localparam int unsigned IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned OW = 11;
  localparam int unsigned RW = ((IW + 1 > OW) ? IW + 1 : OW) + 1;
  localparam int unsigned BW = 14;
  localparam int unsigned PW = RW + BW;
  localparam int unsigned SW = PW + 1;

  logic [12:0]   eff_row;
  logic [CW-1:0] eff_cnt;

  logic [IW-1:0] col_q, row_q, lin_q;
  logic          bank_q, prev_q;

  logic          acc, last, col_wrap;
  logic [IW:0]   lin_inc, col_inc;
  logic [7:0]    xc, yc;
  src_kind_e     kind_d;
  logic signed [OW-1:0] mx, my;
  logic signed [RW-1:0] rowref_d, colref_d;

  logic                 f1_v_q;
  src_kind_e            f1_kind_q;
  logic signed [RW-1:0] f1_rowref_q, f1_colref_q;
  logic [IW-1:0]        f1_idx_q;
  logic                 f1_bank_q, f1_prev_q, f1_done_q;
  logic [31:0]          f1_lit_q;

  logic                 f2_v_q;
  src_kind_e            f2_kind_q;
  logic signed [PW-1:0] f2_prod_q;
  logic signed [RW-1:0] f2_colref_q;
  logic [IW-1:0]        f2_idx_q;
  logic                 f2_bank_q, f2_prev_q, f2_done_q;
  logic [31:0]          f2_lit_q;

  logic                 f1_free, f2_free;
  logic signed [SW-1:0] ref_s;
  logic                 ref_out, ref_ahead;
  fault_e               fault_d;
  logic                 rd_en_d, rd_bank_d;

  assign eff_row = (cfg_i.blocks_per_row == '0) ? 13'd1 : cfg_i.blocks_per_row;

  always_comb begin
    if (cfg_i.block_count == '0) begin
      eff_cnt = CW'(1);
    end else if (32'(cfg_i.block_count) > MAX_BLOCKS) begin
      eff_cnt = CW'(MAX_BLOCKS);
    end else begin
      eff_cnt = CW'(cfg_i.block_count);
    end
  end

  // Handshake along the two front stages
  assign f2_free     = ~f2_v_q | ~job_full_i;
  assign f1_free     = ~f1_v_q | f2_free;
  assign in_stall_o  = ~f1_free;
  assign acc         = in_valid_i & ~in_stall_o;
  assign job_valid_o = f2_v_q;

  // Classify and form the signed row and column references
  assign xc = in_data_i.motion_x_code;
  assign yc = in_data_i.motion_y_code;

  always_comb begin
    if (xc == LITERAL_CODE && yc == LITERAL_CODE) begin
      kind_d = SRC_LITERAL;
    end else if ((xc & INTER_FLAG) != '0 && (yc & INTER_FLAG) != '0) begin
      kind_d = SRC_INTER;
    end else begin
      kind_d = SRC_INTRA;
    end
  end

  always_comb begin
    if (kind_d == SRC_INTER) begin
      mx = $signed({3'b000, xc & OFFSET_MASK}) - $signed({4'b0000, cfg_i.offset_bias});
      my = $signed({3'b000, yc & OFFSET_MASK}) - $signed({4'b0000, cfg_i.offset_bias});
    end else begin
      mx = $signed({3'b000, xc}) - $signed({4'b0000, cfg_i.offset_bias});
      my = $signed({3'b000, yc}) - $signed({3'b000, cfg_i.offset_bias, 1'b0}) + 11'sd1;
    end
  end

  assign rowref_d = RW'($signed({1'b0, row_q})) + RW'(my);
  assign colref_d = RW'($signed({1'b0, col_q})) + RW'(mx);

  // Raster position bookkeeping
  assign lin_inc  = {1'b0, lin_q} + 1'b1;
  assign col_inc  = {1'b0, col_q} + 1'b1;
  assign last     = lin_inc >= (IW + 1)'(eff_cnt);
  assign col_wrap = 32'(col_inc) >= 32'(eff_row);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      lin_q  <= '0;
      bank_q <= 1'b0;
      prev_q <= 1'b0;
      f1_v_q <= 1'b0;
      f2_v_q <= 1'b0;
    end else begin
      if (acc) begin
        if (last) begin
          col_q  <= '0;
          row_q  <= '0;
          lin_q  <= '0;
          bank_q <= ~bank_q;
          prev_q <= 1'b1;
        end else begin
          lin_q <= lin_inc[IW-1:0];
          if (col_wrap) begin
            col_q <= '0;
            row_q <= row_q + 1'b1;
          end else begin
            col_q <= col_inc[IW-1:0];
          end
        end
      end
      if (f1_free) begin
        f1_v_q <= in_valid_i;
      end
      if (f2_free) begin
        f2_v_q <= f1_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      f1_kind_q   <= kind_d;
      f1_rowref_q <= rowref_d;
      f1_colref_q <= colref_d;
      f1_idx_q    <= lin_q;
      f1_bank_q   <= bank_q;
      f1_prev_q   <= prev_q;
      f1_done_q   <= last;
      f1_lit_q    <= in_data_i.literal_word;
    end
    if (f2_free && f1_v_q) begin
      f2_kind_q   <= f1_kind_q;
      f2_prod_q   <= PW'(f1_rowref_q) * PW'($signed({1'b0, eff_row}));
      f2_colref_q <= f1_colref_q;
      f2_idx_q    <= f1_idx_q;
      f2_bank_q   <= f1_bank_q;
      f2_prev_q   <= f1_prev_q;
      f2_done_q   <= f1_done_q;
      f2_lit_q    <= f1_lit_q;
    end
  end

  // Linear reference, range checks and fault priority
  assign ref_s     = SW'(f2_prod_q) + SW'(f2_colref_q);
  assign ref_out   = ref_s[SW-1] || (ref_s >= $signed({{(SW - CW){1'b0}}, eff_cnt}));
  assign ref_ahead = ref_s >= $signed({{(SW - IW){1'b0}}, f2_idx_q});

  always_comb begin
    fault_d   = FLT_NONE;
    rd_en_d   = 1'b0;
    rd_bank_d = f2_bank_q;
    case (f2_kind_q)
      SRC_INTER: begin
        rd_bank_d = ~f2_bank_q;
        if (!f2_prev_q) begin
          fault_d = FLT_NO_PREV;
        end else if (ref_out) begin
          fault_d = FLT_RANGE;
        end else begin
          rd_en_d = 1'b1;
        end
      end
      SRC_INTRA: begin
        if (ref_out) begin
          fault_d = FLT_RANGE;
        end else if (ref_ahead) begin
          fault_d = FLT_NOT_DECODED;
        end else begin
          rd_en_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    job_o.index        = IDX_MAX_W'(f2_idx_q);
    job_o.cur_bank     = f2_bank_q;
    job_o.rd_en        = rd_en_d;
    job_o.rd_bank      = rd_bank_d;
    job_o.rd_index     = IDX_MAX_W'(ref_s[IW-1:0]);
    job_o.kind         = f2_kind_q;
    job_o.fault        = fault_d;
    job_o.frame_done   = f2_done_q;
    job_o.literal_word = f2_lit_q;
  end

  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && last) |=> (lin_q == '0 && col_q == '0 && prev_q))
    else $error("raster position not cleared after last block of frame");

  a_intra_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_valid_o && job_o.rd_en && job_o.kind == SRC_INTRA) |-> job_o.rd_index < job_o.index)
    else $error("intra read issued at or beyond the current block");

endmodule

/* rtl/bmir_fifo.sv */
module bmir_fifo import bmir_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  output logic valid_o,
  input  logic pop_i,
  output job_t data_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  job_t             entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]   count_q;
  logic             do_push, do_pop;

  assign full_o  = count_q == (PTR_W + 1)'(QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;
  assign data_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (PTR_W + 1)'(QUEUE_DEPTH))
    else $error("queue holds more transactions than it has entries");

endmodule

/* rtl/bmir_back.sv */
module bmir_back import bmir_pkg::*; #(
  parameter int unsigned MAX_BLOCKS = 4096
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic job_valid_i,
  input  job_t job_i,
  output logic job_pop_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam int unsigned IW    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned AW    = IW + 1;
  localparam int unsigned DEPTH = 2 ** AW;

  // Both frame stores, bank in the top address bit
  logic [31:0]   store_q [DEPTH];
  logic [31:0]   rd_data_q;

  logic          s2_v_q;
  job_t          s2_job_q;
  logic          fwd_q;
  logic [31:0]   fwd_word_q;
  logic [31:0]   s2_word;

  logic          out_v_q;
  out_t          out_q;

  logic          out_free, s2_free, s2_adv, pop;
  logic [AW-1:0] waddr, raddr;

  assign out_free  = ~out_v_q | ~out_stall_i;
  assign s2_adv    = s2_v_q & out_free;
  assign s2_free   = ~s2_v_q | out_free;
  assign pop       = job_valid_i & s2_free;
  assign job_pop_o = pop;

  assign waddr = {s2_job_q.cur_bank, s2_job_q.index[IW-1:0]};
  assign raddr = {job_i.rd_bank, job_i.rd_index[IW-1:0]};

  always_comb begin
    if (s2_job_q.kind == SRC_LITERAL) begin
      s2_word = s2_job_q.literal_word;
    end else if (!s2_job_q.rd_en) begin
      s2_word = '0;
    end else if (fwd_q) begin
      s2_word = fwd_word_q;
    end else begin
      s2_word = rd_data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      store_q[waddr] <= s2_word;
    end
    if (pop) begin
      rd_data_q <= store_q[raddr];
      s2_job_q  <= job_i;
      // Read lands on the word being written this edge: take it from the bypass
      fwd_q      <= s2_adv && (waddr == raddr);
      fwd_word_q <= s2_word;
    end
    if (s2_adv) begin
      out_q.block_index <= s2_job_q.index[11:0];
      out_q.interp_word <= s2_word;
      out_q.source_kind <= s2_job_q.kind;
      out_q.fault       <= s2_job_q.fault;
      out_q.frame_done  <= s2_job_q.frame_done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s2_free) begin
        s2_v_q <= job_valid_i;
      end
      if (out_free) begin
        out_v_q <= s2_v_q;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.fault != FLT_NONE) |-> out_data_o.interp_word == '0)
    else $error("faulted block carries a non-zero word");

  a_next_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && out_data_o.frame_done)
      |=> (!out_valid_o || out_data_o.block_index == '0))
    else $error("frame did not restart at block zero");

  a_raster_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !out_data_o.frame_done)
      |=> (!out_valid_o || out_data_o.block_index == $past(out_data_o.block_index) + 12'd1))
    else $error("blocks left out of raster order");

endmodule

/* bench/block_motion_index_reconstruct_unit_tb.sv */
`timescale 1ns / 1ps

module block_motion_index_reconstruct_unit_tb;
  import bmir_pkg::*;

  localparam int unsigned STORE_DEPTH    = 4096;
  localparam int unsigned CYCLE_LIMIT    = 400000;
  localparam int unsigned TAIL_CYCLES    = 8;
  localparam int unsigned HOLDOFF_CYCLES = 300;
  localparam int unsigned RANDOM_BURST   = 110;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_t                   in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_t                  out_data;

  // Shadow of the block: frame stores, raster counters and register copies
  logic [31:0] store_word    [2][STORE_DEPTH];
  bit          store_written [2][STORE_DEPTH];
  bit          cur_bank = 1'b0;
  bit          have_prev = 1'b0;
  int          blk_pos = 0;
  int          col_pos = 0;
  int          row_pos = 0;
  logic [12:0] row_len_reg = RST_BLOCKS_PER_ROW;
  logic [12:0] frame_len_reg = RST_BLOCK_COUNT;
  logic [6:0]  bias_reg = RST_OFFSET_BIAS;

  out_t pending_blocks [$];
  int   mismatches = 0;
  int   blocks_sent = 0;
  int   frames_closed = 0;
  int   kind_hits [4];
  int   fault_hits [4];
  int   cycle_count = 0;
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  int   holdoff_left = 0;

  block_motion_index_reconstruct_unit #(
    .MAX_BLOCKS (STORE_DEPTH)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Rebuild the word of the block at the current raster position. Flags a read of a
  // previous-frame entry that was never written.
  function automatic out_t reconstruct_block(in_t blk, output bit unsafe);
    out_t        r;
    longint      per_row, frame_len, bias, dx, dy, ref_idx;
    logic [7:0]  xc, yc;
    xc = blk.motion_x_code;
    yc = blk.motion_y_code;
    per_row = (row_len_reg == 0) ? 1 : row_len_reg;
    frame_len = (frame_len_reg == 0) ? 1 :
                (frame_len_reg > STORE_DEPTH) ? STORE_DEPTH : frame_len_reg;
    bias = bias_reg;
    unsafe = 1'b0;
    r.block_index = 12'(blk_pos);
    r.interp_word = '0;
    r.fault = FLT_NONE;
    r.frame_done = (blk_pos + 1 >= frame_len);
    if (xc == LITERAL_CODE && yc == LITERAL_CODE) begin
      r.source_kind = SRC_LITERAL;
      r.interp_word = blk.literal_word;
    end else if ((xc & INTER_FLAG) != 0 && (yc & INTER_FLAG) != 0) begin
      r.source_kind = SRC_INTER;
      dx = longint'(xc & OFFSET_MASK) - bias;
      dy = longint'(yc & OFFSET_MASK) - bias;
      ref_idx = (row_pos + dy) * per_row + (col_pos + dx);
      if (!have_prev) begin
        r.fault = FLT_NO_PREV;
      end else if (ref_idx < 0 || ref_idx >= frame_len) begin
        r.fault = FLT_RANGE;
      end else begin
        unsafe = !store_written[!cur_bank][ref_idx];
        r.interp_word = store_word[!cur_bank][ref_idx];
      end
    end else begin
      r.source_kind = SRC_INTRA;
      dx = longint'(xc) - bias;
      dy = longint'(yc) - 2 * bias + 1;
      ref_idx = (row_pos + dy) * per_row + (col_pos + dx);
      if (ref_idx < 0 || ref_idx >= frame_len) begin
        r.fault = FLT_RANGE;
      end else if (ref_idx >= blk_pos) begin
        r.fault = FLT_NOT_DECODED;
      end else begin
        r.interp_word = store_word[cur_bank][ref_idx];
      end
    end
    return r;
  endfunction

  // Store the word and step the raster position; swap banks at the end of a frame
  function automatic void advance_raster(out_t r);
    store_word[cur_bank][blk_pos] = r.interp_word;
    store_written[cur_bank][blk_pos] = 1'b1;
    if (r.frame_done) begin
      blk_pos = 0;
      col_pos = 0;
      row_pos = 0;
      cur_bank = !cur_bank;
      have_prev = 1'b1;
      frames_closed++;
    end else begin
      blk_pos++;
      col_pos++;
      if (col_pos >= ((row_len_reg == 0) ? 1 : int'(row_len_reg))) begin
        col_pos = 0;
        row_pos++;
      end
    end
  endfunction

  // Mostly well-formed codes near the bias, so references land near the current block
  function automatic in_t random_block();
    in_t blk;
    int  pick, dx, dy;
    pick = $urandom_range(99);
    dx = int'($urandom_range(5)) - 3;
    dy = int'($urandom_range(2)) - 2;
    blk.literal_word = $urandom;
    if (pick < 15) begin
      blk.motion_x_code = LITERAL_CODE;
      blk.motion_y_code = LITERAL_CODE;
    end else if (pick < 50) begin
      blk.motion_x_code = 8'(int'(bias_reg) + dx) | INTER_FLAG;
      blk.motion_y_code = 8'(int'(bias_reg) + dy + 1) | INTER_FLAG;
    end else if (pick < 88) begin
      blk.motion_x_code = 8'(int'(bias_reg) + dx);
      blk.motion_y_code = 8'(2 * int'(bias_reg) - 1 + dy);
    end else begin
      blk.motion_x_code = 8'($urandom);
      blk.motion_y_code = 8'($urandom);
    end
    return blk;
  endfunction

  // One transaction on the input channel; predict once it is accepted
  task automatic send_block(in_t blk);
    out_t pred;
    bit   unsafe;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= blk;
    do @(posedge clk); while (in_stall);
    pred = reconstruct_block(blk, unsafe);
    pending_blocks.push_back(pred);
    blocks_sent++;
    kind_hits[pred.source_kind]++;
    fault_hits[pred.fault]++;
    advance_raster(pred);
  endtask

  // Never reference an unwritten previous-frame entry: fall back to a literal
  task automatic offer_block(in_t blk);
    out_t pred;
    bit   unsafe;
    pred = reconstruct_block(blk, unsafe);
    if (unsafe) begin
      blk.motion_x_code = LITERAL_CODE;
      blk.motion_y_code = LITERAL_CODE;
    end
    send_block(blk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_blocks.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic configure(logic [12:0] row_len, logic [12:0] frame_blocks,
                           logic [6:0] bias);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_idx <= CFG_BLOCKS_PER_ROW;
    cfg_wdata <= row_len;
    @(posedge clk);
    row_len_reg = row_len;
    cfg_idx <= CFG_BLOCK_COUNT;
    cfg_wdata <= frame_blocks;
    @(posedge clk);
    frame_len_reg = frame_blocks;
    // upper bits must be dropped by the register
    cfg_idx <= CFG_OFFSET_BIAS;
    cfg_wdata <= {6'($urandom), bias};
    @(posedge clk);
    bias_reg = bias;
    cfg_idx <= CFG_SPARE_IDX;
    cfg_wdata <= 13'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Reset register values: missing previous frame, not-yet-decoded, bypass, range, literals
  task automatic test_reset_defaults();
    send_idle_pct = 0;
    stall_pct = 0;
    offer_block(in_t'{8'h90, 8'h90, $urandom});
    offer_block(in_t'{8'd16, 8'd31, $urandom});
    offer_block(in_t'{LITERAL_CODE, LITERAL_CODE, 32'h0000_0000});
    offer_block(in_t'{LITERAL_CODE, LITERAL_CODE, 32'hFFFF_FFFF});
    offer_block(in_t'{8'd15, 8'd31, $urandom});
    offer_block(in_t'{8'd0, 8'd0, $urandom});
    offer_block(in_t'{8'h7F, 8'hFF, $urandom});
    offer_block(in_t'{8'hFF, 8'hFE, $urandom});
    offer_block(in_t'{8'd14, 8'd31, $urandom});
  endtask

  // Small frame: ends mid-way after the change, then inter copies, range and wrap cases
  task automatic test_directed_cases();
    configure(13'd4, 13'd10, 7'd16);
    offer_block(in_t'{8'd12, 8'd31, $urandom});
    offer_block(in_t'{8'h90, 8'h90, $urandom});
    offer_block(in_t'{8'h91, 8'h91, $urandom});
    offer_block(in_t'{8'hFF, 8'h80, $urandom});
    offer_block(in_t'{8'h80, 8'hFF, $urandom});
    offer_block(in_t'{LITERAL_CODE, LITERAL_CODE, $urandom});
    offer_block(in_t'{8'd15, 8'd31, $urandom});
    offer_block(in_t'{8'd18, 8'd30, $urandom});
    offer_block(in_t'{8'd16, 8'd31, $urandom});
    offer_block(in_t'{8'h91, 8'h90, $urandom});
    offer_block(in_t'{8'hFF, 8'h7F, $urandom});
  endtask

  // Zero row length and block count act as one; an oversized block count clamps to the store depth
  task automatic test_register_extremes();
    configure(13'd0, 13'd0, 7'd0);
    offer_block(in_t'{8'h80, 8'h80, $urandom});
    offer_block(in_t'{8'd0, 8'd0, $urandom});
    offer_block(in_t'{LITERAL_CODE, LITERAL_CODE, $urandom});
    configure(13'h1FFF, 13'h1FFF, 7'd127);
    offer_block(in_t'{8'd127, 8'd253, $urandom});
    offer_block(in_t'{8'hFF, 8'hFE, $urandom});
    offer_block(in_t'{8'hFE, 8'hFF, $urandom});
  endtask

  // Hold the output for a long stretch so the pipeline and queue fill up
  task automatic test_backpressure();
    configure(13'd5, 13'd20, 7'd8);
    send_idle_pct = 0;
    stall_pct = 0;
    holdoff_left = HOLDOFF_CYCLES;
    repeat (60) offer_block(random_block());
  endtask

  task automatic test_random_traffic();
    int          pick;
    logic [12:0] row_len, frame_blocks;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 77; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 77; end
        default: begin send_idle_pct = 31; stall_pct = 31; end
      endcase
      for (int k = 0; k < 2; k++) begin
        pick = $urandom_range(9);
        row_len = (pick == 0) ? 13'd0 :
                  (pick == 1) ? 13'($urandom_range(4096, 8191)) :
                  13'($urandom_range(1, 9));
        frame_blocks = (pick == 2) ? 13'd0 :
                       (pick == 3) ? 13'd4096 :
                       13'($urandom_range(1, 48));
        configure(row_len, frame_blocks, 7'($urandom_range(127)));
        repeat (RANDOM_BURST) offer_block(random_block());
      end
    end
  endtask

  always @(posedge clk) begin
    if (holdoff_left > 0) begin
      out_stall <= 1'b1;
      holdoff_left = holdoff_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Compare every accepted result with the oldest prediction
  always @(posedge clk) begin
    out_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_blocks.size() == 0) begin
        mismatches++;
        $display("%0t: expected nothing, got idx=%0d word=%h kind=%0d fault=%0d done=%0d",
                 $realtime, out_data.block_index, out_data.interp_word,
                 out_data.source_kind, out_data.fault, out_data.frame_done);
      end else begin
        want = pending_blocks.pop_front();
        if (out_data.block_index !== want.block_index ||
            out_data.interp_word !== want.interp_word ||
            out_data.source_kind !== want.source_kind ||
            out_data.fault !== want.fault ||
            out_data.frame_done !== want.frame_done) begin
          mismatches++;
          $display("%0t: expected idx=%0d word=%h kind=%0d fault=%0d done=%0d",
                   $realtime, want.block_index, want.interp_word, want.source_kind,
                   want.fault, want.frame_done);
          $display("%0t:   actual idx=%0d word=%h kind=%0d fault=%0d done=%0d",
                   $realtime, out_data.block_index, out_data.interp_word,
                   out_data.source_kind, out_data.fault, out_data.frame_done);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding",
               cycle_count, pending_blocks.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_directed_cases();
    test_register_extremes();
    test_backpressure();
    test_random_traffic();
    wait_idle();
    $display("checked %0d blocks across %0d frame ends: %0d literal, %0d inter, %0d intra",
             blocks_sent, frames_closed, kind_hits[SRC_LITERAL], kind_hits[SRC_INTER],
             kind_hits[SRC_INTRA]);
    $display("faults: %0d outside frame, %0d without previous frame, %0d not yet decoded",
             fault_hits[FLT_RANGE], fault_hits[FLT_NO_PREV], fault_hits[FLT_NOT_DECODED]);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/bmir_pkg.sv
rtl/bmir_front.sv
rtl/bmir_fifo.sv
rtl/bmir_back.sv
rtl/block_motion_index_reconstruct_unit.sv
bench/block_motion_index_reconstruct_unit_tb.sv
